### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### design/mva_pkg.sv
// ----------------------------------------------------------------------------
// mva_pkg
// types and codes of the mpe voice allocator
// ----------------------------------------------------------------------------
`default_nettype none

package mva_pkg;

    localparam int VOICE_SLOTS_DEF = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_MASTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd3;

    localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
    localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
    localparam logic [2:0] CMD_BEND     = 3'd2;
    localparam logic [2:0] CMD_PRESSURE = 3'd3;
    localparam logic [2:0] CMD_CC       = 3'd4;
    localparam logic [2:0] CMD_RELEASE  = 3'd5;

    localparam logic [2:0] MODE_NONE   = 3'd0;
    localparam logic [2:0] MODE_RR     = 3'd1;
    localparam logic [2:0] MODE_OLDEST = 3'd2;
    localparam logic [2:0] MODE_LOW    = 3'd3;
    localparam logic [2:0] MODE_HIGH   = 3'd4;
    localparam logic [2:0] MODE_QUIET  = 3'd5;

    localparam logic [1:0] KIND_ON   = 2'd0;
    localparam logic [1:0] KIND_OFF  = 2'd1;
    localparam logic [1:0] KIND_UPD  = 2'd2;
    localparam logic [1:0] KIND_FAIL = 2'd3;

    localparam logic [6:0]  CC_BRIGHT   = 7'd74;
    localparam logic [6:0]  CC_TIMBRE   = 7'd1;
    localparam logic [31:0] BEND_CENTER = 32'h8000_0000;
    localparam logic [31:0] TIMBRE_INIT = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  midi_channel;
        logic [6:0]  note_number;
        logic [15:0] note_velocity;
        logic [31:0] ctrl_value;
        logic [6:0]  ctrl_number;
    } in_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [4:0]  voice_channel;
        logic [6:0]  voice_note;
        logic [15:0] voice_velocity;
        logic [31:0] voice_bend;
        logic [31:0] voice_pressure;
        logic [31:0] voice_bright;
        logic [31:0] voice_timbre;
        logic        last_of_run;
    } out_t;

    typedef struct packed {
        logic [6:0]  note;
        logic [15:0] velocity;
        logic [31:0] bend;
        logic [31:0] pressure;
        logic [31:0] bright;
        logic [31:0] timbre;
        logic [31:0] stamp;
    } voice_t;

endpackage

`default_nettype wire

### design/mpe_voice_allocator.sv
// ----------------------------------------------------------------------------
// mpe_voice_allocator
// mpe voice table with round robin allocation and voice stealing
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | word
//  s_       | in        | s_valid / s_ready  | in_t midi event
//  m_       | out       | m_valid / m_ready  | out_t voice event
//  cfg_     | in        | cfg_we             | register write, no wait
//
//  one event at a time; a word is registered in idle and decoded in dispatch
//  a note-on steal search, a master note-off, master bend and release all
//  sweep the voice ram one entry a cycle unless held by the output
//  the voice ram read port sets that rate
//  a full output register stalls the off, bend and release sweeps in place
//  reset clears active flags and control; no ram clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mpe_voice_allocator #(
    parameter int VOICE_SLOTS = mva_pkg::VOICE_SLOTS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire mva_pkg::in_t                    s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output mva_pkg::out_t                        m_data,
    input  wire logic                            cfg_we,
    input  wire logic [mva_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mva_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import mva_pkg::*;

    localparam int IDX_W = $clog2(VOICE_SLOTS);
    localparam int CW    = IDX_W + 1;
    localparam int VW    = $bits(voice_t);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DISPATCH, ST_SCAN, ST_SINGLE, ST_OLD, ST_NEW, ST_FAIL
    } state_t;

    typedef enum logic [1:0] {OP_STEAL, OP_OFFM, OP_BENDALL, OP_REL} scan_op_t;

    state_t             state_reg, state_next;
    scan_op_t           op_reg, op_next;
    in_t                in_reg, in_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic [IDX_W-1:0]   vidx_reg, vidx_next;
    logic [IDX_W-1:0]   pick_reg, pick_next;
    logic [31:0]        best_reg, best_next;
    logic               have_reg, have_next;
    logic [VOICE_SLOTS-1:0] active_reg, active_next;
    logic [IDX_W-1:0]   rr_reg, rr_next;
    logic [31:0]        zbend_reg, zbend_next;
    logic [31:0]        zbright_reg, zbright_next;
    logic [31:0]        stamp_reg, stamp_next;
    logic [3:0]         master_reg, master_next;
    logic [3:0]         start_reg, start_next;
    logic [4:0]         count_reg, count_next;
    logic [2:0]         mode_reg, mode_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    voice_t             ram_wdata, rd;
    logic [VW-1:0]      ram_rdata;

    logic [CW-1:0]      n_usable;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               out_free;

    mva_ram #(
        .WIDTH (VW),
        .DEPTH (VOICE_SLOTS)
    ) u_voice_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd       = voice_t'(ram_rdata);
    assign n_usable = (count_reg > 5'(VOICE_SLOTS)) ? CW'(VOICE_SLOTS) : CW'(count_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    function automatic out_t make_out(logic [1:0] kind, logic [4:0] ch, voice_t v,
                                      logic last);
        out_t o;
        o.event_kind     = kind;
        o.voice_channel  = ch;
        o.voice_note     = v.note;
        o.voice_velocity = v.velocity;
        o.voice_bend     = v.bend;
        o.voice_pressure = v.pressure;
        o.voice_bright   = v.bright;
        o.voice_timbre   = v.timbre;
        o.last_of_run    = last;
        return o;
    endfunction

    // round robin search for a free voice among the usable ones
    always_comb begin
        logic [CW-1:0] pos;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < VOICE_SLOTS; i++) begin
            pos = CW'(rr_reg) + CW'(i);
            if (pos >= n_usable) begin
                pos = pos - n_usable;
            end
            if (!free_found && CW'(i) < n_usable && !active_reg[pos[IDX_W-1:0]]) begin
                free_found = 1'b1;
                free_idx   = pos[IDX_W-1:0];
            end
        end
    end

    always_comb begin
        logic [3:0]       ch;
        logic [3:0]       diff;
        logic             is_master, member, vact;
        logic [4:0]       ch_sum;
        logic [CW-1:0]    rr_inc, fr_inc;
        logic [4:0]       vch, sch;
        voice_t           upd, nv;
        voice_t           fail_v;
        logic             act, at_end, adv, above, better, take;
        logic [31:0]      key;
        logic [IDX_W-1:0] pick_sel;

        state_next   = state_reg;
        op_next      = op_reg;
        in_next      = in_reg;
        scan_next    = scan_reg;
        vidx_next    = vidx_reg;
        pick_next    = pick_reg;
        best_next    = best_reg;
        have_next    = have_reg;
        active_next  = active_reg;
        rr_next      = rr_reg;
        zbend_next   = zbend_reg;
        zbright_next = zbright_reg;
        stamp_next   = stamp_reg;
        master_next  = master_reg;
        start_next   = start_reg;
        count_next   = count_reg;
        mode_next    = mode_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = vidx_reg;
        ram_wdata    = rd;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        ch        = in_reg.midi_channel;
        diff      = ch - start_reg;
        is_master = (ch == master_reg);
        ch_sum    = {1'b0, start_reg} + 5'(n_usable);
        member    = (ch >= start_reg) && ({1'b0, ch} < ch_sum);
        vact      = (ch >= start_reg) && (5'(diff) < 5'(VOICE_SLOTS))
                    && active_reg[diff[IDX_W-1:0]];
        rr_inc    = CW'(rr_reg) + CW'(1);
        fr_inc    = CW'(free_idx) + CW'(1);
        vch       = 5'(start_reg) + 5'(vidx_reg);
        sch       = 5'(start_reg) + 5'(scan_reg);

        upd = rd;
        unique case (in_reg.cmd)
            CMD_BEND:     upd.bend     = in_reg.ctrl_value;
            CMD_PRESSURE: upd.pressure = in_reg.ctrl_value;
            CMD_CC: begin
                if (in_reg.ctrl_number == CC_BRIGHT) begin
                    upd.bright = in_reg.ctrl_value;
                end else begin
                    upd.timbre = in_reg.ctrl_value;
                end
            end
            default: upd = rd;
        endcase

        nv.note     = in_reg.note_number;
        nv.velocity = in_reg.note_velocity;
        nv.bend     = zbend_reg;
        nv.pressure = '0;
        nv.bright   = zbright_reg;
        nv.timbre   = TIMBRE_INIT;
        nv.stamp    = stamp_reg;

        fail_v          = '0;
        fail_v.note     = in_reg.note_number;
        fail_v.velocity = in_reg.note_velocity;

        act    = active_reg[scan_reg];
        at_end = (scan_reg == IDX_W'(VOICE_SLOTS - 1));
        adv    = 1'b0;
        above  = 1'b0;
        for (int j = 0; j < VOICE_SLOTS; j++) begin
            if (IDX_W'(j) > scan_reg && active_reg[j]) begin
                above = 1'b1;
            end
        end

        key    = '0;
        better = 1'b0;
        case (mode_reg)
            MODE_OLDEST: begin
                key    = stamp_reg - rd.stamp;
                better = key > best_reg;
            end
            MODE_LOW: begin
                key    = 32'(rd.note);
                better = key < best_reg;
            end
            MODE_HIGH: begin
                key    = 32'(rd.note);
                better = key > best_reg;
            end
            MODE_QUIET: begin
                key    = 32'(rd.velocity);
                better = key < best_reg;
            end
            default: begin
                key    = '0;
                better = 1'b0;
            end
        endcase
        take     = act && (!have_reg || better);
        pick_sel = take ? scan_reg : pick_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH: begin
                state_next = ST_IDLE;
                scan_next  = '0;
                have_next  = 1'b0;
                unique case (in_reg.cmd)
                    CMD_NOTE_ON: begin
                        if (member || is_master) begin
                            if (n_usable == '0) begin
                                state_next = ST_FAIL;
                            end else if (free_found) begin
                                vidx_next  = free_idx;
                                rr_next    = (fr_inc == n_usable) ? '0 : fr_inc[IDX_W-1:0];
                                state_next = ST_NEW;
                            end else if (mode_reg == MODE_RR) begin
                                vidx_next  = rr_reg;
                                rr_next    = (rr_inc == n_usable) ? '0 : rr_inc[IDX_W-1:0];
                                ram_re     = 1'b1;
                                ram_raddr  = rr_reg;
                                state_next = ST_OLD;
                            end else if (mode_reg >= MODE_OLDEST && mode_reg <= MODE_QUIET) begin
                                ram_re     = 1'b1;
                                op_next    = OP_STEAL;
                                state_next = ST_SCAN;
                            end else begin
                                state_next = ST_FAIL;
                            end
                        end
                    end
                    CMD_NOTE_OFF: begin
                        if (member) begin
                            if (vact) begin
                                vidx_next  = diff[IDX_W-1:0];
                                ram_re     = 1'b1;
                                ram_raddr  = diff[IDX_W-1:0];
                                state_next = ST_SINGLE;
                            end
                        end else if (is_master) begin
                            ram_re     = 1'b1;
                            op_next    = OP_OFFM;
                            state_next = ST_SCAN;
                        end
                    end
                    CMD_BEND: begin
                        if (is_master) begin
                            zbend_next = in_reg.ctrl_value;
                            ram_re     = 1'b1;
                            op_next    = OP_BENDALL;
                            state_next = ST_SCAN;
                        end else if (vact) begin
                            vidx_next  = diff[IDX_W-1:0];
                            ram_re     = 1'b1;
                            ram_raddr  = diff[IDX_W-1:0];
                            state_next = ST_SINGLE;
                        end
                    end
                    CMD_PRESSURE: begin
                        if (!is_master && vact) begin
                            vidx_next  = diff[IDX_W-1:0];
                            ram_re     = 1'b1;
                            ram_raddr  = diff[IDX_W-1:0];
                            state_next = ST_SINGLE;
                        end
                    end
                    CMD_CC: begin
                        if (in_reg.ctrl_number == CC_BRIGHT && is_master) begin
                            zbright_next = in_reg.ctrl_value;
                        end else if ((in_reg.ctrl_number == CC_BRIGHT
                                      || in_reg.ctrl_number == CC_TIMBRE) && vact) begin
                            vidx_next  = diff[IDX_W-1:0];
                            ram_re     = 1'b1;
                            ram_raddr  = diff[IDX_W-1:0];
                            state_next = ST_SINGLE;
                        end
                    end
                    CMD_RELEASE: begin
                        rr_next    = '0;
                        ram_re     = 1'b1;
                        op_next    = OP_REL;
                        state_next = ST_SCAN;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end

            ST_SCAN: begin
                // rd holds the entry at scan_reg; it holds while the sweep stalls
                unique case (op_reg)
                    OP_STEAL: begin
                        if (take) begin
                            pick_next = scan_reg;
                            best_next = key;
                            have_next = 1'b1;
                        end
                        adv = 1'b1;
                    end
                    OP_OFFM: begin
                        if (act && rd.note == in_reg.note_number) begin
                            if (out_free) begin
                                active_next[scan_reg] = 1'b0;
                                m_valid_next = 1'b1;
                                m_data_next  = make_out(KIND_OFF, sch, rd, 1'b1);
                                state_next   = ST_IDLE;
                            end
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    OP_BENDALL, OP_REL: begin
                        if (act) begin
                            if (out_free) begin
                                if (op_reg == OP_REL) begin
                                    active_next[scan_reg] = 1'b0;
                                end
                                m_valid_next = 1'b1;
                                m_data_next  = make_out((op_reg == OP_REL) ? KIND_OFF : KIND_UPD,
                                                        sch, rd, !above);
                                adv = 1'b1;
                            end
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    default: adv = 1'b1;
                endcase
                if (adv) begin
                    if (at_end) begin
                        if (op_reg == OP_STEAL) begin
                            vidx_next  = pick_sel;
                            ram_re     = 1'b1;
                            ram_raddr  = pick_sel;
                            state_next = ST_OLD;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        scan_next = scan_reg + IDX_W'(1);
                        ram_re    = 1'b1;
                        ram_raddr = scan_reg + IDX_W'(1);
                    end
                end
            end

            ST_SINGLE: begin
                if (in_reg.cmd == CMD_NOTE_OFF) begin
                    if (rd.note != in_reg.note_number) begin
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        active_next[vidx_reg] = 1'b0;
                        m_valid_next = 1'b1;
                        m_data_next  = make_out(KIND_OFF, vch, rd, 1'b1);
                        state_next   = ST_IDLE;
                    end
                end else if (out_free) begin
                    ram_we       = 1'b1;
                    ram_wdata    = upd;
                    m_valid_next = 1'b1;
                    m_data_next  = make_out(KIND_UPD, vch, upd, 1'b1);
                    state_next   = ST_IDLE;
                end
            end

            ST_OLD: begin
                // stolen voice: report old contents first
                if (!active_reg[vidx_reg]) begin
                    state_next = ST_NEW;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = make_out(KIND_OFF, vch, rd, 1'b0);
                    state_next   = ST_NEW;
                end
            end

            ST_NEW: begin
                if (out_free) begin
                    ram_we                = 1'b1;
                    ram_wdata             = nv;
                    active_next[vidx_reg] = 1'b1;
                    stamp_next            = stamp_reg + 32'd1;
                    m_valid_next          = 1'b1;
                    m_data_next           = make_out(KIND_ON, vch, nv, 1'b1);
                    state_next            = ST_IDLE;
                end
            end

            ST_FAIL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = make_out(KIND_FAIL, 5'd0, fail_v, 1'b1);
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_MASTER: master_next = cfg_wdata[3:0];
                CFG_START:  start_next  = cfg_wdata[3:0];
                CFG_COUNT:  count_next  = cfg_wdata;
                CFG_MODE:   mode_next   = cfg_wdata[2:0];
                default:    mode_next   = mode_reg;
            endcase
            active_next = '0;
            rr_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= '0;
            rr_reg      <= '0;
            zbend_reg   <= BEND_CENTER;
            zbright_reg <= '0;
            stamp_reg   <= '0;
            master_reg  <= 4'd0;
            start_reg   <= 4'd1;
            count_reg   <= 5'd15;
            mode_reg    <= MODE_OLDEST;
            m_valid_reg <= 1'b0;
            have_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            rr_reg      <= rr_next;
            zbend_reg   <= zbend_next;
            zbright_reg <= zbright_next;
            stamp_reg   <= stamp_next;
            master_reg  <= master_next;
            start_reg   <= start_next;
            count_reg   <= count_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
            have_reg    <= have_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        in_reg     <= in_next;
        scan_reg   <= scan_next;
        vidx_reg   <= vidx_next;
        pick_reg   <= pick_next;
        best_reg   <= best_next;
        m_data_reg <= m_data_next;
    end

    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "second word taken while busy")
    `ASSERT_ALWAYS(a_active_bound, aclk, aresetn, $countones(active_reg) <= 32'(n_usable), "more active voices than usable")
    `ASSERT_ALWAYS(a_rr_range, aclk, aresetn, (CW'(rr_reg) < n_usable) || (rr_reg == '0), "round robin pointer out of range")

endmodule

`default_nettype wire

### design/mva_ram.sv
// ----------------------------------------------------------------------------
// mva_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        // read data holds while re is low
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire
